[rtl/frt_pkg.sv]
// ----------------------------------------------------------------------------
// frt_pkg
// Shared types and constants of the flow rate table and IP id rewriter.
// ----------------------------------------------------------------------------
package frt_pkg;

    localparam logic [7:0]  PROTO_TCP       = 8'd6;
    localparam logic [7:0]  PROTO_UDP       = 8'd17;
    localparam logic [15:0] TCP_OTHER_ID    = 16'd65535;
    localparam logic [15:0] UDP_ID          = 16'd65534;
    localparam logic [7:0]  LOCAL_OCTET_RST = 8'd10;

    localparam logic OP_INBOUND  = 1'b0;
    localparam logic OP_OUTBOUND = 1'b1;

    // Register index, taken from paddr[2].
    localparam logic REG_LISTENER = 1'b0;
    localparam logic REG_LOCAL    = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic load;
        logic scan;
        logic commit;
    } dp_cmd_t;

    typedef struct packed {
        logic scan_done;
        logic out_free;
    } dp_stat_t;

    typedef struct packed {
        logic [31:0] src;
        logic [31:0] dst;
        logic [15:0] rate;
    } flow_entry_t;

endpackage

[rtl/frt_ctrl.sv]
// ----------------------------------------------------------------------------
// frt_ctrl
// Sequencer: takes a header word, runs the table scan, then commits the result.
// ----------------------------------------------------------------------------
module frt_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  frt_pkg::dp_stat_t stat,
    output frt_pkg::dp_cmd_t  cmd
);

    frt_pkg::state_t state_reg;
    frt_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= frt_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            frt_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = frt_pkg::ST_SCAN;
                end
            end
            frt_pkg::ST_SCAN:
            begin
                if (stat.scan_done)
                begin
                    state_next = frt_pkg::ST_FINISH;
                end
            end
            frt_pkg::ST_FINISH:
            begin
                if (stat.out_free)
                begin
                    state_next = frt_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = frt_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_stall = 1'b1;
        unique case (state_reg)
            frt_pkg::ST_IDLE:
            begin
                in_stall = 1'b0;
                cmd.load = in_valid;
            end
            frt_pkg::ST_SCAN:
            begin
                cmd.scan = 1'b1;
            end
            frt_pkg::ST_FINISH:
            begin
                cmd.commit = stat.out_free;
            end
            default:
            begin
                in_stall = 1'b1;
            end
        endcase
    end

endmodule

[rtl/frt_dp.sv]
// ----------------------------------------------------------------------------
// frt_dp
// Datapath: header registers, flow table memory with its scan engine,
// id and checksum rewrite, and the result register.
// ----------------------------------------------------------------------------
module frt_dp
#(
    parameter int TABLE_DEPTH = 64
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  frt_pkg::dp_cmd_t  cmd,
    output frt_pkg::dp_stat_t stat,
    input  logic              listener_enabled,
    input  logic [7:0]        local_octet,
    input  logic              opcode,
    input  logic [7:0]        protocol,
    input  logic [31:0]       src_addr,
    input  logic [31:0]       dst_addr,
    input  logic [15:0]       ip_id,
    input  logic [15:0]       ip_checksum,
    input  logic              tcp_ack,
    input  logic              tcp_psh,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [15:0]       new_id,
    output logic [15:0]       new_checksum,
    output logic              report_valid,
    output logic [31:0]       report_src,
    output logic [31:0]       report_dst,
    output logic [15:0]       report_rate
);

    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

    function automatic logic [15:0] csum_update(
        input logic [15:0] chk,
        input logic [15:0] from_id,
        input logic [15:0] to_id
    );
        logic [17:0] sum;
        logic [16:0] fold;
        sum  = {2'b00, ~chk} + {2'b00, ~from_id} + {2'b00, to_id};
        fold = {1'b0, sum[15:0]} + {15'b0, sum[17:16]};
        return ~(fold[15:0] + {15'b0, fold[16]});
    endfunction

    // Captured header.
    logic        op_reg;
    logic [7:0]  proto_reg;
    logic [31:0] src_reg;
    logic [31:0] dst_reg;
    logic [15:0] id_reg;
    logic [15:0] chk_reg;
    logic        ack_reg;
    logic        psh_reg;

    // Flow table and scan engine.
    frt_pkg::flow_entry_t flow_mem [TABLE_DEPTH];
    frt_pkg::flow_entry_t rd_data_reg;
    logic [CNT_W-1:0]     fill_reg;
    logic [CNT_W-1:0]     fill_next;
    logic [CNT_W-1:0]     addr_reg;
    logic [CNT_W-1:0]     addr_next;
    logic                 pend_reg;
    logic                 pend_next;
    logic [IDX_W-1:0]     pidx_reg;
    logic [IDX_W-1:0]     pidx_next;
    logic                 hit_reg;
    logic [IDX_W-1:0]     hit_idx_reg;
    logic [15:0]          hit_rate_reg;

    // Result register.
    logic        out_valid_reg;
    logic        out_valid_next;
    logic [15:0] new_id_reg;
    logic [15:0] new_chk_reg;
    logic        rv_reg;
    logic [31:0] rs_reg;
    logic [31:0] rd_reg;
    logic [15:0] rr_reg;

    logic                 is_local;
    logic                 is_inbound;
    logic                 is_tcp;
    logic                 is_udp;
    logic                 is_ack;
    logic                 search;
    logic                 update;
    logic                 more;
    logic                 issue;
    logic                 match;
    logic                 full;
    logic                 mem_we;
    logic [IDX_W-1:0]     mem_waddr;
    frt_pkg::flow_entry_t mem_wdata;
    logic                 rewrite;
    logic [15:0]          res_id;
    logic [15:0]          res_chk;
    logic                 res_rv;
    logic [31:0]          res_rs;
    logic [31:0]          res_rd;
    logic [15:0]          res_rr;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg    <= opcode;
            proto_reg <= protocol;
            src_reg   <= src_addr;
            dst_reg   <= dst_addr;
            id_reg    <= ip_id;
            chk_reg   <= ip_checksum;
            ack_reg   <= tcp_ack;
            psh_reg   <= tcp_psh;
        end
    end

    always_comb
    begin
        is_local   = (src_reg[7:0] == local_octet);
        is_inbound = (op_reg == frt_pkg::OP_INBOUND);
        is_tcp     = (proto_reg == frt_pkg::PROTO_TCP);
        is_udp     = (proto_reg == frt_pkg::PROTO_UDP);
        is_ack     = is_tcp && ack_reg && !psh_reg && (dst_reg[31:24] < src_reg[31:24]);
        update     = is_local && is_inbound && is_tcp && !is_ack;
        search     = update || (is_local && !is_inbound && is_ack);
        full       = (fill_reg == CNT_W'(TABLE_DEPTH));
    end

    // The scan reads one entry a cycle; the compare sees the word read the
    // cycle before, so the first match stops further reads.
    always_comb
    begin
        more           = (addr_reg < fill_reg);
        match          = pend_reg && (rd_data_reg.src == src_reg) &&
                         (rd_data_reg.dst == dst_reg);
        issue          = cmd.scan && search && !match && more;
        stat.scan_done = !search || match || (!pend_reg && !more);
        stat.out_free  = !out_valid_reg || !out_stall;

        addr_next = addr_reg;
        pend_next = pend_reg;
        pidx_next = pidx_reg;
        if (cmd.load)
        begin
            addr_next = '0;
            pend_next = 1'b0;
        end
        else if (cmd.scan)
        begin
            pend_next = issue;
            if (issue)
            begin
                pidx_next = addr_reg[IDX_W-1:0];
                addr_next = addr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            addr_reg <= '0;
            pend_reg <= 1'b0;
        end
        else
        begin
            addr_reg <= addr_next;
            pend_reg <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pidx_reg <= pidx_next;
        if (cmd.scan && stat.scan_done)
        begin
            hit_reg      <= search && match;
            hit_idx_reg  <= pidx_reg;
            hit_rate_reg <= rd_data_reg.rate;
        end
    end

    // Write on a learn commit: refresh a known flow, else append if room.
    always_comb
    begin
        mem_we         = 1'b0;
        mem_waddr      = hit_idx_reg;
        mem_wdata.src  = src_reg;
        mem_wdata.dst  = dst_reg;
        mem_wdata.rate = id_reg;
        fill_next      = fill_reg;
        if (cmd.commit && update)
        begin
            if (hit_reg)
            begin
                mem_we = 1'b1;
            end
            else if (!full)
            begin
                mem_we    = 1'b1;
                mem_waddr = fill_reg[IDX_W-1:0];
                fill_next = fill_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            flow_mem[mem_waddr] <= mem_wdata;
        end
        if (issue)
        begin
            rd_data_reg <= flow_mem[addr_reg[IDX_W-1:0]];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= '0;
        end
        else
        begin
            fill_reg <= fill_next;
        end
    end

    always_comb
    begin
        rewrite = 1'b0;
        res_id  = id_reg;
        res_rv  = 1'b0;
        res_rs  = '0;
        res_rd  = '0;
        res_rr  = '0;
        if (is_local && !is_inbound)
        begin
            if (is_ack)
            begin
                if (hit_reg)
                begin
                    rewrite = 1'b1;
                    res_id  = hit_rate_reg;
                end
            end
            else if (is_tcp)
            begin
                rewrite = 1'b1;
                res_id  = frt_pkg::TCP_OTHER_ID;
            end
            else if (is_udp)
            begin
                rewrite = 1'b1;
                res_id  = frt_pkg::UDP_ID;
            end
        end
        if (is_local && is_inbound && listener_enabled)
        begin
            if (is_udp)
            begin
                res_rv = 1'b1;
                res_rs = dst_reg;
                res_rd = src_reg;
                res_rr = id_reg;
            end
            else if (is_ack)
            begin
                res_rv = 1'b1;
                res_rs = src_reg;
                res_rd = dst_reg;
                res_rr = id_reg;
            end
        end
        res_chk = rewrite ? csum_update(chk_reg, id_reg, res_id) : chk_reg;
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.commit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            new_id_reg  <= res_id;
            new_chk_reg <= res_chk;
            rv_reg      <= res_rv;
            rs_reg      <= res_rs;
            rd_reg      <= res_rd;
            rr_reg      <= res_rr;
        end
    end

    assign out_valid    = out_valid_reg;
    assign new_id       = new_id_reg;
    assign new_checksum = new_chk_reg;
    assign report_valid = rv_reg;
    assign report_src   = rs_reg;
    assign report_dst   = rd_reg;
    assign report_rate  = rr_reg;

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= CNT_W'(TABLE_DEPTH))
        else $error("flow table fill count beyond depth");

    a_fill_step: assert property (@(posedge clk) disable iff (!rst_n)
        (fill_reg != $past(fill_reg)) |-> (fill_reg == $past(fill_reg) + 1'b1))
        else $error("flow table fill count moved by more than one");

    a_no_write_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> !cmd.scan)
        else $error("flow table written during a scan");

    a_commit_out: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |=> out_valid_reg)
        else $error("committed result not presented");

endmodule

[rtl/flow_rate_table_id_rewriter_unit.sv]
// ----------------------------------------------------------------------------
// flow_rate_table_id_rewriter_unit
// Flow rate table with IP identification rewrite and rate reporting.
// Takes one header word at a time: a new word is accepted only while idle,
// after the serial table scan and the commit of the previous result.
// Reset: table empty (fill count zero), listener off, local octet 10.
// ----------------------------------------------------------------------------
module flow_rate_table_id_rewriter_unit
#(
    parameter int TABLE_DEPTH = 64
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        opcode,
    input  logic [7:0]  protocol,
    input  logic [31:0] src_addr,
    input  logic [31:0] dst_addr,
    input  logic [15:0] ip_id,
    input  logic [15:0] ip_checksum,
    input  logic        tcp_ack,
    input  logic        tcp_psh,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [15:0] new_id,
    output logic [15:0] new_checksum,
    output logic        report_valid,
    output logic [31:0] report_src,
    output logic [31:0] report_dst,
    output logic [15:0] report_rate
);

    logic              listener_reg;
    logic [7:0]        local_octet_reg;
    logic              cfg_write;
    frt_pkg::dp_cmd_t  cmd;
    frt_pkg::dp_stat_t stat;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            listener_reg    <= 1'b0;
            local_octet_reg <= frt_pkg::LOCAL_OCTET_RST;
        end
        else if (cfg_write)
        begin
            unique case (paddr[2])
                frt_pkg::REG_LISTENER: listener_reg    <= pwdata[0];
                frt_pkg::REG_LOCAL:    local_octet_reg <= pwdata[7:0];
                default:               listener_reg    <= listener_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            frt_pkg::REG_LISTENER: prdata = {31'b0, listener_reg};
            frt_pkg::REG_LOCAL:    prdata = {24'b0, local_octet_reg};
            default:               prdata = '0;
        endcase
    end

    frt_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .stat     (stat),
        .cmd      (cmd)
    );

    frt_dp
    #(
        .TABLE_DEPTH (TABLE_DEPTH)
    )
    u_dp
    (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .stat             (stat),
        .listener_enabled (listener_reg),
        .local_octet      (local_octet_reg),
        .opcode           (opcode),
        .protocol         (protocol),
        .src_addr         (src_addr),
        .dst_addr         (dst_addr),
        .ip_id            (ip_id),
        .ip_checksum      (ip_checksum),
        .tcp_ack          (tcp_ack),
        .tcp_psh          (tcp_psh),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .new_id           (new_id),
        .new_checksum     (new_checksum),
        .report_valid     (report_valid),
        .report_src       (report_src),
        .report_dst       (report_dst),
        .report_rate      (report_rate)
    );

endmodule

[verif/flow_table_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// flow_table_checker
// Watches the header, result and register channels of the flow rate table,
// keeps its own copy of the flow table and settings, predicts each result
// word and compares it field by field with what the block returns.
// ----------------------------------------------------------------------------
module flow_table_checker
#(
    parameter int SLOTS = 64
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic [31:0] prdata,
    input  logic        pready,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic        opcode,
    input  logic [7:0]  protocol,
    input  logic [31:0] src_addr,
    input  logic [31:0] dst_addr,
    input  logic [15:0] ip_id,
    input  logic [15:0] ip_checksum,
    input  logic        tcp_ack,
    input  logic        tcp_psh,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic [15:0] new_id,
    input  logic [15:0] new_checksum,
    input  logic        report_valid,
    input  logic [31:0] report_src,
    input  logic [31:0] report_dst,
    input  logic [15:0] report_rate,
    output int          errors,
    output int          waiting,
    output int          checked,
    output int          reports
);

    typedef struct packed {
        logic [15:0] id;
        logic [15:0] checksum;
        logic        rpt_valid;
        logic [31:0] rpt_src;
        logic [31:0] rpt_dst;
        logic [15:0] rpt_rate;
    } hdr_result_t;

    logic [31:0] slot_src  [SLOTS];
    logic [31:0] slot_dst  [SLOTS];
    logic [15:0] slot_rate [SLOTS];
    int          used_slots;
    logic        listen_on;
    logic [7:0]  home_octet;

    hdr_result_t expected_q [$];

    int n_errors  = 0;
    int n_waiting = 0;
    int n_checked = 0;
    int n_reports = 0;

    assign errors  = n_errors;
    assign waiting = n_waiting;
    assign checked = n_checked;
    assign reports = n_reports;

    // Incremental header checksum update for a changed 16-bit word.
    function automatic logic [15:0] csum_adjust(input logic [15:0] old_sum,
                                                input logic [15:0] old_word,
                                                input logic [15:0] new_word);
        logic [17:0] acc;
        acc = {2'b00, ~old_sum} + {2'b00, ~old_word} + {2'b00, new_word};
        acc = {2'b00, acc[15:0]} + {16'd0, acc[17:16]};
        acc = {2'b00, acc[15:0]} + {16'd0, acc[17:16]};
        return ~acc[15:0];
    endfunction

    function automatic int lookup_flow(input logic [31:0] s, input logic [31:0] d);
        for (int i = 0; i < used_slots; i++)
        begin
            if (slot_src[i] == s && slot_dst[i] == d)
                return i;
        end
        return -1;
    endfunction

    // Applies one header to the table copy and returns the word it yields.
    function automatic hdr_result_t apply_header(input logic        op,
                                                 input logic [7:0]  proto,
                                                 input logic [31:0] src,
                                                 input logic [31:0] dst,
                                                 input logic [15:0] id,
                                                 input logic [15:0] chk,
                                                 input logic        ack,
                                                 input logic        psh);
        hdr_result_t r;
        int          hit;
        logic        is_tcp;
        logic        is_udp;
        logic        is_ack;
        r          = '0;
        r.id       = id;
        r.checksum = chk;
        is_tcp     = (proto == frt_pkg::PROTO_TCP);
        is_udp     = (proto == frt_pkg::PROTO_UDP);
        is_ack     = is_tcp && ack && !psh && (dst[31:24] < src[31:24]);
        if (src[7:0] == home_octet)
        begin
            if (op == frt_pkg::OP_INBOUND)
            begin
                if (is_udp)
                begin
                    if (listen_on)
                    begin
                        r.rpt_valid = 1'b1;
                        r.rpt_src   = dst;
                        r.rpt_dst   = src;
                        r.rpt_rate  = id;
                    end
                end
                else if (is_ack)
                begin
                    if (listen_on)
                    begin
                        r.rpt_valid = 1'b1;
                        r.rpt_src   = src;
                        r.rpt_dst   = dst;
                        r.rpt_rate  = id;
                    end
                end
                else if (is_tcp)
                begin
                    hit = lookup_flow(src, dst);
                    if (hit >= 0)
                    begin
                        slot_rate[hit] = id;
                    end
                    else if (used_slots < SLOTS)
                    begin
                        slot_src[used_slots]  = src;
                        slot_dst[used_slots]  = dst;
                        slot_rate[used_slots] = id;
                        used_slots++;
                    end
                end
            end
            else
            begin
                if (is_ack)
                begin
                    hit = lookup_flow(src, dst);
                    if (hit >= 0)
                    begin
                        r.id       = slot_rate[hit];
                        r.checksum = csum_adjust(chk, id, r.id);
                    end
                end
                else if (is_tcp)
                begin
                    r.id       = frt_pkg::TCP_OTHER_ID;
                    r.checksum = csum_adjust(chk, id, r.id);
                end
                else if (is_udp)
                begin
                    r.id       = frt_pkg::UDP_ID;
                    r.checksum = csum_adjust(chk, id, r.id);
                end
            end
        end
        return r;
    endfunction

    function automatic void compare_field(input string       name,
                                          input logic [31:0] want,
                                          input logic [31:0] seen);
        if (want !== seen)
        begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, seen);
            n_errors++;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        hdr_result_t want;
        hdr_result_t seen;
        if (!rst_n)
        begin
            for (int i = 0; i < SLOTS; i++)
            begin
                slot_src[i]  = '0;
                slot_dst[i]  = '0;
                slot_rate[i] = '0;
            end
            used_slots = 0;
            listen_on  = 1'b0;
            home_octet = frt_pkg::LOCAL_OCTET_RST;
            expected_q.delete();
            n_waiting  = 0;
        end
        else
        begin
            if (psel && penable && pready)
            begin
                if (pwrite)
                begin
                    if (paddr[2] == frt_pkg::REG_LISTENER)
                        listen_on = pwdata[0];
                    else
                        home_octet = pwdata[7:0];
                end
                else
                begin
                    compare_field("prdata",
                                  (paddr[2] == frt_pkg::REG_LISTENER) ? {31'd0, listen_on}
                                                                      : {24'd0, home_octet},
                                  prdata);
                end
            end

            if (out_valid && !out_stall)
            begin
                seen.id        = new_id;
                seen.checksum  = new_checksum;
                seen.rpt_valid = report_valid;
                seen.rpt_src   = report_src;
                seen.rpt_dst   = report_dst;
                seen.rpt_rate  = report_rate;
                if (expected_q.size() == 0)
                begin
                    $display("%0t: result word with none expected, expected none, actual id %h",
                             $time, new_id);
                    n_errors++;
                end
                else
                begin
                    want = expected_q.pop_front();
                    compare_field("new_id", {16'd0, want.id}, {16'd0, seen.id});
                    compare_field("new_checksum", {16'd0, want.checksum},
                                  {16'd0, seen.checksum});
                    compare_field("report_valid", {31'd0, want.rpt_valid},
                                  {31'd0, seen.rpt_valid});
                    compare_field("report_src", want.rpt_src, seen.rpt_src);
                    compare_field("report_dst", want.rpt_dst, seen.rpt_dst);
                    compare_field("report_rate", {16'd0, want.rpt_rate},
                                  {16'd0, seen.rpt_rate});
                    n_checked++;
                    if (want.rpt_valid)
                        n_reports++;
                end
            end

            if (in_valid && !in_stall)
                expected_q.push_back(apply_header(opcode, protocol, src_addr, dst_addr,
                                                  ip_id, ip_checksum, tcp_ack, tcp_psh));

            n_waiting = expected_q.size();
        end
    end

endmodule

[verif/tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Drives header words through the flow rate table under several register
// settings: a directed pass over the special cases, then random traffic built
// mostly from learn-then-rewrite sequences on a fixed set of flows.
// ----------------------------------------------------------------------------
module tb;

    localparam int         FLOW_SLOTS       = 64;
    localparam int         FLOW_POOL        = 40;
    localparam int         PHASES           = 6;
    localparam int         RANDOM_PER_PHASE = 300;
    localparam int         HOLD_CYCLES      = 400;
    localparam int         CYCLE_LIMIT      = 1000000;
    localparam logic [7:0] PROTO_ICMP       = 8'd1;

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        in_valid;
    logic        in_stall;
    logic        opcode;
    logic [7:0]  protocol;
    logic [31:0] src_addr;
    logic [31:0] dst_addr;
    logic [15:0] ip_id;
    logic [15:0] ip_checksum;
    logic        tcp_ack;
    logic        tcp_psh;
    logic        out_valid;
    logic        out_stall;
    logic [15:0] new_id;
    logic [15:0] new_checksum;
    logic        report_valid;
    logic [31:0] report_src;
    logic [31:0] report_dst;
    logic [15:0] report_rate;

    int errors;
    int waiting;
    int checked;
    int reports;

    logic [23:0] pool_hi  [FLOW_POOL];
    logic [31:0] pool_dst [FLOW_POOL];
    logic [7:0]  home;
    int          burst_left;
    int          sent;
    int          cycles;
    logic        hold_request;

    flow_rate_table_id_rewriter_unit #(.TABLE_DEPTH(FLOW_SLOTS)) DUT (.*);

    flow_table_checker #(.SLOTS(FLOW_SLOTS)) u_check (.*);

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("FAILED: results differ");
            $finish;
        end
    end

    // Result side: the stall pattern is redrawn at random intervals, and a long
    // hold-off on request lets the block back up into its input.
    initial
    begin
        int mode;
        int span;
        out_stall = 1'b0;
        mode      = 0;
        span      = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            if (span <= 0)
            begin
                mode = $urandom_range(0, 3);
                span = $urandom_range(20, 200);
            end
            span--;
            case (mode)
                0:       out_stall <= 1'b0;
                1:       out_stall <= ($urandom_range(0, 9) < 3);
                2:       out_stall <= ($urandom_range(0, 9) < 8);
                default: out_stall <= ~out_stall;
            endcase
        end
    end

    task automatic offer(input logic        op,
                         input logic [7:0]  proto,
                         input logic [31:0] src,
                         input logic [31:0] dst,
                         input logic [15:0] id,
                         input logic [15:0] chk,
                         input logic        ack,
                         input logic        psh);
        in_valid    <= 1'b1;
        opcode      <= op;
        protocol    <= proto;
        src_addr    <= src;
        dst_addr    <= dst;
        ip_id       <= id;
        ip_checksum <= chk;
        tcp_ack     <= ack;
        tcp_psh     <= psh;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        sent++;
        burst_left--;
        if (burst_left <= 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, ($urandom_range(0, 3) == 0) ? 40 : 6)) @(posedge clk);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(60, 150)
                                                     : $urandom_range(1, 12);
        end
    endtask

    task automatic write_reg(input logic idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    task automatic read_reg(input logic idx);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {idx, 2'b00};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    // Waits until every header sent so far has come back, then lets the
    // block sit for longer than a full table scan.
    task automatic settle();
        in_valid <= 1'b0;
        do @(posedge clk); while (waiting != 0);
        repeat (FLOW_SLOTS + 8) @(posedge clk);
    endtask

    task automatic random_header();
        int          k;
        int          pick;
        logic [31:0] s;
        logic [31:0] d;
        logic [15:0] id;
        logic [15:0] chk;
        logic [7:0]  proto;
        logic        ack;
        k    = $urandom_range(0, FLOW_POOL - 1);
        s    = {pool_hi[k], home};
        d    = pool_dst[k];
        id   = 16'($urandom_range(0, 65535));
        chk  = 16'($urandom_range(0, 65535));
        ack  = 1'($urandom_range(0, 1));
        pick = $urandom_range(0, 99);
        if (pick < 25)
        begin
            // Learn a rate: any flag pair except a clean ACK.
            offer(frt_pkg::OP_INBOUND, frt_pkg::PROTO_TCP, s, d, id, chk, ack,
                  ack ? 1'b1 : 1'($urandom_range(0, 1)));
        end
        else if (pick < 50)
        begin
            offer(frt_pkg::OP_OUTBOUND, frt_pkg::PROTO_TCP, s, d, id, chk, 1'b1, 1'b0);
        end
        else if (pick < 58)
        begin
            offer(frt_pkg::OP_INBOUND, frt_pkg::PROTO_TCP, s, d, id, chk, 1'b1, 1'b0);
        end
        else if (pick < 66)
        begin
            offer(frt_pkg::OP_OUTBOUND, frt_pkg::PROTO_TCP, s, d, id, chk, ack,
                  1'($urandom_range(0, 1)));
        end
        else if (pick < 76)
        begin
            s       = $urandom;
            s[7:0]  = home;
            offer(1'($urandom_range(0, 1)), frt_pkg::PROTO_UDP, s, $urandom, id, chk, ack,
                  1'($urandom_range(0, 1)));
        end
        else if (pick < 88)
        begin
            s      = $urandom;
            s[7:0] = home;
            case ($urandom_range(0, 2))
                0:       proto = frt_pkg::PROTO_TCP;
                1:       proto = frt_pkg::PROTO_UDP;
                default: proto = 8'($urandom_range(0, 255));
            endcase
            offer(1'($urandom_range(0, 1)), proto, s, $urandom, id, chk, ack,
                  1'($urandom_range(0, 1)));
        end
        else
        begin
            offer(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)), $urandom, $urandom,
                  id, chk, ack, 1'($urandom_range(0, 1)));
        end
    endtask

    initial
    begin
        logic        listen_plan [PHASES];
        logic [7:0]  octet_plan  [PHASES];
        logic [31:0] f_src;
        logic [31:0] f_dst;
        logic [31:0] word;
        int          top;

        rst_n        = 1'b0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        in_valid     = 1'b0;
        opcode       = frt_pkg::OP_INBOUND;
        protocol     = '0;
        src_addr     = '0;
        dst_addr     = '0;
        ip_id        = '0;
        ip_checksum  = '0;
        tcp_ack      = 1'b0;
        tcp_psh      = 1'b0;
        hold_request = 1'b0;
        sent         = 0;
        cycles       = 0;
        burst_left   = 1;
        home         = frt_pkg::LOCAL_OCTET_RST;

        listen_plan = '{1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1};
        octet_plan  = '{frt_pkg::LOCAL_OCTET_RST, frt_pkg::LOCAL_OCTET_RST, 8'd0, 8'd255,
                        8'($urandom_range(1, 254)), frt_pkg::LOCAL_OCTET_RST};

        // Pool flows have a destination top byte below the source top byte,
        // so the same pair can be learned and later rewritten as an ACK.
        for (int k = 0; k < FLOW_POOL; k++)
        begin
            top         = $urandom_range(1, 255);
            word        = $urandom;
            pool_hi[k]  = {top[7:0], word[15:0]};
            word        = $urandom;
            word[31:24] = 8'($urandom_range(0, top - 1));
            pool_dst[k] = word;
        end

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        read_reg(frt_pkg::REG_LISTENER);
        read_reg(frt_pkg::REG_LOCAL);

        f_src = 32'hC0A8_010A;
        f_dst = 32'h0A00_0001;

        // Reset settings: listener off, local octet 10.
        offer(frt_pkg::OP_INBOUND, frt_pkg::PROTO_UDP, 32'h1234_560A, 32'h89AB_CDEF,
              16'h0101, 16'h2020, 1'b0, 1'b0);
        offer(frt_pkg::OP_INBOUND, frt_pkg::PROTO_TCP, f_src, f_dst, 16'h1234, 16'hBEEF,
              1'b0, 1'b1);
        offer(frt_pkg::OP_OUTBOUND, frt_pkg::PROTO_TCP, f_src, f_dst, 16'hFFFF, 16'h0000,
              1'b1, 1'b0);
        offer(frt_pkg::OP_OUTBOUND, frt_pkg::PROTO_UDP, 32'hC0A8_010B, f_dst, 16'h0042,
              16'h3030, 1'b0, 1'b0);
        offer(frt_pkg::OP_OUTBOUND, PROTO_ICMP, f_src, f_dst, 16'h0043, 16'h4040,
              1'b0, 1'b0);

        for (int p = 0; p < PHASES; p++)
        begin
            if (p > 0)
            begin
                settle();
                write_reg(frt_pkg::REG_LISTENER, {31'd0, listen_plan[p]});
                write_reg(frt_pkg::REG_LOCAL, {24'd0, octet_plan[p]});
                home = octet_plan[p];
                read_reg(frt_pkg::REG_LISTENER);
                read_reg(frt_pkg::REG_LOCAL);
            end
            if (p == 1)
            begin
                offer(frt_pkg::OP_INBOUND, frt_pkg::PROTO_UDP, 32'hFFFF_FF0A, 32'hFFFF_FFFF,
                      16'hFFFF, 16'hFFFF, 1'b1, 1'b1);
                offer(frt_pkg::OP_INBOUND, frt_pkg::PROTO_TCP, f_src, f_dst, 16'h5A5A,
                      16'h1111, 1'b1, 1'b0);
                offer(frt_pkg::OP_INBOUND, frt_pkg::PROTO_TCP, f_src, f_dst, 16'hABCD,
                      16'h2222, 1'b1, 1'b1);
                // Rewrite to the id the packet already carries.
                offer(frt_pkg::OP_OUTBOUND, frt_pkg::PROTO_TCP, f_src, f_dst, 16'hABCD,
                      16'hFFFF, 1'b1, 1'b0);
                offer(frt_pkg::OP_OUTBOUND, frt_pkg::PROTO_TCP, f_src, f_dst, 16'hABCD,
                      16'h0000, 1'b1, 1'b0);
                offer(frt_pkg::OP_OUTBOUND, frt_pkg::PROTO_TCP, 32'hFF00_000A, 32'h0000_0000,
                      16'h0000, 16'h0000, 1'b1, 1'b0);
                offer(frt_pkg::OP_OUTBOUND, frt_pkg::PROTO_TCP, f_src, f_dst, 16'h0000,
                      16'h0000, 1'b0, 1'b1);
                // ACK flags, but the destination top byte is not below the source's.
                offer(frt_pkg::OP_OUTBOUND, frt_pkg::PROTO_TCP, 32'h0A00_000A, 32'hC000_0000,
                      16'h0001, 16'h5555, 1'b1, 1'b0);
                offer(frt_pkg::OP_OUTBOUND, frt_pkg::PROTO_UDP, f_src, f_dst, 16'hFFFF,
                      16'hFFFF, 1'b0, 1'b0);
                offer(frt_pkg::OP_INBOUND, frt_pkg::PROTO_TCP, 32'h0A00_000A, 32'hC000_0000,
                      16'h7777, 16'h0000, 1'b1, 1'b0);
            end
            if (p == 2)
            begin
                // Local octet 0 allows an all-zero source to be learned.
                offer(frt_pkg::OP_INBOUND, frt_pkg::PROTO_TCP, 32'h0, 32'h0, 16'h4444,
                      16'h0F0F, 1'b0, 1'b0);
                offer(frt_pkg::OP_INBOUND, frt_pkg::PROTO_TCP, 32'h0, 32'h0, 16'h8888,
                      16'hF0F0, 1'b0, 1'b0);
                offer(frt_pkg::OP_INBOUND, frt_pkg::PROTO_TCP, 32'h0100_0000, 32'h0,
                      16'h0303, 16'h0000, 1'b0, 1'b1);
                offer(frt_pkg::OP_OUTBOUND, frt_pkg::PROTO_TCP, 32'h0100_0000, 32'h0,
                      16'hFFFF, 16'h1234, 1'b1, 1'b0);
                offer(frt_pkg::OP_INBOUND, frt_pkg::PROTO_UDP, 32'h0, 32'hFFFF_FFFF,
                      16'h9999, 16'h0000, 1'b0, 1'b0);
            end
            if (p == 1 || p == 4)
                hold_request = 1'b1;
            repeat (RANDOM_PER_PHASE) random_header();
        end

        settle();
        $display("Sent %0d headers across %0d register settings.", sent, PHASES);
        $display("Compared %0d result words, %0d of them carrying a rate report.",
                 checked, reports);
        if (errors == 0 && waiting == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

[flow_rate_table_id_rewriter_unit.f]
rtl/frt_pkg.sv
rtl/frt_ctrl.sv
rtl/frt_dp.sv
rtl/flow_rate_table_id_rewriter_unit.sv
verif/flow_table_checker.sv
verif/tb.sv
